/* rtl/face_classifier_hash_table_core_assert.svh */
// Assertion macros used by the checker file of the face classifier hash table.
`ifndef FACE_CLASSIFIER_HASH_TABLE_CORE_ASSERT_SVH
`define FACE_CLASSIFIER_HASH_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising edge of i_clk outside reset.
`define FCT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising edge of i_clk outside reset.
`define FCT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/fct_pkg.sv */
// Types, codes and helper functions of the face classifier hash table.
`default_nettype none

package fct_pkg;

    // Result status codes.
    localparam logic [3:0] STAT_NEW_QUAL    = 4'd0;
    localparam logic [3:0] STAT_NEW_REJECT  = 4'd1;
    localparam logic [3:0] STAT_REPEAT_QUAL = 4'd2;
    localparam logic [3:0] STAT_INVALIDATED = 4'd3;
    localparam logic [3:0] STAT_REPEAT_NOT  = 4'd4;
    localparam logic [3:0] STAT_FULL        = 4'd5;
    localparam logic [3:0] STAT_CLEARED     = 4'd6;
    localparam logic [3:0] STAT_DISABLED    = 4'd7;
    localparam logic [3:0] STAT_BAD_KEY     = 4'd8;

    // Reject reason numbers.
    localparam logic [3:0] REASON_FOG      = 4'd8;
    localparam logic [3:0] REASON_DLIGHT   = 4'd9;
    localparam logic [3:0] REASON_GEOMETRY = 4'd12;
    localparam logic [3:0] REASON_NONE     = 4'd13;

    // Item kinds.
    localparam logic KIND_FACE  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    // Hash finalizer multipliers.
    localparam logic [31:0] HASH_MUL_A = 32'h7feb352d;
    localparam logic [31:0] HASH_MUL_B = 32'h846ca68b;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        HS_IDLE,
        HS_SECOND,
        HS_DONE
    } t_hash_step;

    typedef struct packed {
        logic [31:0] key;
        logic        qual;
        logic [19:0] bytes;
    } t_entry;

    typedef struct packed {
        logic [3:0]  status;
        logic [11:0] slot;
        logic [3:0]  reason;
        logic [12:0] rmask;
        logic [19:0] bytes;
    } t_res_core;

    typedef struct packed {
        t_res_core   core;
        logic [12:0] unique_count;
        logic [12:0] qualifying_count;
        logic [31:0] total_cache_bytes;
        logic [31:0] draw_calls;
        logic [31:0] qualifying_draw_calls;
        logic [31:0] overflow_draw_calls;
    } t_result;

    // Lowest set reject bit, or no reason when the mask is empty.
    function automatic logic [3:0] first_reason(input logic [12:0] m);
        logic [3:0] r;
        r = REASON_NONE;
        for (int i = 12; i >= 0; i--) begin
            if (m[i]) begin
                r = 4'(i);
            end
        end
        return r;
    endfunction

    // Vertex bytes (24 per point) plus index bytes (2 per index), each rounded
    // up to 16 bytes. Its result is only used for nonnegative counts.
    function automatic logic [19:0] cache_bytes(input logic [15:0] p, input logic [15:0] ix);
        logic [19:0] pb;
        logic [19:0] ib;
        pb = ({4'b0, p} << 4) + ({4'b0, p} << 3);
        pb = (pb + 20'd15) & ~20'd15;
        ib = {4'b0, ix} << 1;
        ib = (ib + 20'd15) & ~20'd15;
        return pb + ib;
    endfunction

endpackage

`default_nettype wire

/* rtl/fct_if.sv */
// Valid/ready channel interfaces for input items and result items.
`default_nettype none

interface fct_item_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [31:0]        face_key;
    logic [12:0]        shader_reject_mask;
    logic               fog_present;
    logic               dlight_present;
    logic signed [15:0] point_count;
    logic signed [15:0] index_count;

    modport source (
        output valid, kind, face_key, shader_reject_mask, fog_present,
               dlight_present, point_count, index_count,
        input  ready
    );
    modport sink (
        input  valid, kind, face_key, shader_reject_mask, fog_present,
               dlight_present, point_count, index_count,
        output ready
    );
endinterface

interface fct_result_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic [11:0] slot_index;
    logic [3:0]  first_reason;
    logic [12:0] reject_mask;
    logic [19:0] cache_bytes;
    logic [12:0] unique_count;
    logic [12:0] qualifying_count;
    logic [31:0] total_cache_bytes;
    logic [31:0] draw_calls;
    logic [31:0] qualifying_draw_calls;
    logic [31:0] overflow_draw_calls;

    modport source (
        output valid, status, slot_index, first_reason, reject_mask, cache_bytes,
               unique_count, qualifying_count, total_cache_bytes, draw_calls,
               qualifying_draw_calls, overflow_draw_calls,
        input  ready
    );
    modport sink (
        input  valid, status, slot_index, first_reason, reject_mask, cache_bytes,
               unique_count, qualifying_count, total_cache_bytes, draw_calls,
               qualifying_draw_calls, overflow_draw_calls,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/fct_hash.sv */
// Key hash finalizer built around one shared 32-bit multiplier over two steps.
`default_nettype none

module fct_hash (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_key,
    output logic             o_done,
    output logic [31:0]      o_hash
);

    fct_pkg::t_hash_step r_step;
    fct_pkg::t_hash_step n_step;
    logic [31:0] r_prod;
    logic [31:0] n_prod;
    logic [31:0] mul_a;
    logic [31:0] mul_b;

    always_comb begin
        n_step = r_step;
        unique case (r_step)
            fct_pkg::HS_IDLE:   if (i_start) n_step = fct_pkg::HS_SECOND;
            fct_pkg::HS_SECOND: n_step = fct_pkg::HS_DONE;
            fct_pkg::HS_DONE:   n_step = fct_pkg::HS_IDLE;
            default:            n_step = fct_pkg::HS_IDLE;
        endcase
    end

    // The first step mixes the incoming key, the second the first product.
    always_comb begin
        if (r_step == fct_pkg::HS_IDLE) begin
            mul_a = i_key ^ (i_key >> 16);
            mul_b = fct_pkg::HASH_MUL_A;
        end else begin
            mul_a = r_prod ^ (r_prod >> 15);
            mul_b = fct_pkg::HASH_MUL_B;
        end
        n_prod = mul_a * mul_b;
        o_done = (r_step == fct_pkg::HS_DONE);
        o_hash = r_prod ^ (r_prod >> 16);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= fct_pkg::HS_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_step != fct_pkg::HS_DONE) begin
            r_prod <= n_prod;
        end
    end

endmodule

`default_nettype wire

/* rtl/fct_ram.sv */
// Single-port slot memory with registered read data.
`default_nettype none

module fct_ram #(
    parameter int ADDR_BITS = 12,
    parameter int DATA_BITS = 53
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic                 i_re,
    input  wire logic [ADDR_BITS-1:0] i_addr,
    input  wire logic [DATA_BITS-1:0] i_wdata,
    output logic [DATA_BITS-1:0]      o_rdata
);

    logic [DATA_BITS-1:0] r_mem [2**ADDR_BITS];
    logic [DATA_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/face_classifier_hash_table_core.sv */
// Top level of the face classifier hash table: sequencer, counters and result register.
`default_nettype none

// Face classifier hash table. Each input transaction is either a face sighting
// or a clear command. A sighting's 32-bit key is hashed with a two-multiply
// finalizer, which runs on one shared multiplier in two steps, and the
// result selects the start slot of a linearly probed table of 2**TABLE_BITS
// slots held in a single-port memory. The sequencer reads one slot per cycle
// until it finds the key or an empty slot, then writes the slot back if the
// face is new or loses its qualifying status. A sighting probes from 1 up to
// 2**TABLE_BITS slots. Disabled sightings, zero keys and clear commands skip
// the hash and the probe and go from the idle state straight to the done
// state. The block takes one transaction at a time: ready is high only in
// the idle state, while the result register still lets a finished result
// wait for the consumer as the next transaction comes in. After reset and
// after every clear command the table is wiped by a pass that writes one
// slot per cycle, during which no transaction is accepted; configuration
// writes are taken at any time. Every result carries the running counters
// as they stand after its transaction.

module face_classifier_hash_table_core #(
    parameter int TABLE_BITS = 12
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_cfg_we,
    input  wire logic     i_cfg_wdata,
    fct_item_if.sink      i_item,
    fct_result_if.source  o_result
);

    localparam int ENTRY_BITS = $bits(fct_pkg::t_entry);

    fct_pkg::t_state r_state;
    fct_pkg::t_state n_state;

    // Control registers.
    logic [TABLE_BITS-1:0] r_sweep;
    logic [TABLE_BITS-1:0] n_sweep;
    logic                  r_enable;
    logic                  r_wipe;
    logic                  n_wipe;
    logic                  r_out_valid;
    logic                  n_out_valid;

    // Running counters.
    logic [12:0] r_unique;
    logic [12:0] n_unique;
    logic [12:0] r_qual;
    logic [12:0] n_qual;
    logic [31:0] r_btot;
    logic [31:0] n_btot;
    logic [31:0] r_sight;
    logic [31:0] n_sight;
    logic [31:0] r_qsight;
    logic [31:0] n_qsight;
    logic [31:0] r_oflow;
    logic [31:0] n_oflow;

    // Payload registers of the transaction in flight.
    logic [31:0]           r_key;
    logic [31:0]           n_key;
    logic [12:0]           r_mask;
    logic [12:0]           n_mask;
    logic                  r_fog;
    logic                  n_fog;
    logic                  r_dl;
    logic                  n_dl;
    logic [15:0]           r_points;
    logic [15:0]           n_points;
    logic [15:0]           r_indices;
    logic [15:0]           n_indices;
    logic [TABLE_BITS-1:0] r_idx;
    logic [TABLE_BITS-1:0] n_idx;
    logic [TABLE_BITS-1:0] r_probe;
    logic [TABLE_BITS-1:0] n_probe;
    fct_pkg::t_res_core    r_res;
    fct_pkg::t_res_core    n_res;
    fct_pkg::t_result      r_out;
    fct_pkg::t_result      n_out;

    // Handshake and datapath controls.
    logic                  accept;
    logic                  out_free;
    logic                  hash_start;
    logic                  hash_done;
    logic [31:0]           hash_val;
    logic                  ram_we;
    logic                  ram_re;
    logic [TABLE_BITS-1:0] ram_addr;
    fct_pkg::t_entry       ram_wdata;
    logic [ENTRY_BITS-1:0] ram_rdata;
    fct_pkg::t_entry       slot_ent;
    logic                  slot_empty;
    logic                  slot_hit;
    logic                  probe_last;
    logic [12:0]           new_rmask;
    logic [19:0]           new_bytes;

    assign accept   = i_item.valid && i_item.ready;
    assign out_free = !r_out_valid || o_result.ready;

    assign slot_ent   = fct_pkg::t_entry'(ram_rdata);
    assign slot_empty = (slot_ent.key == 32'd0);
    assign slot_hit   = (slot_ent.key == r_key);
    assign probe_last = (r_probe == {TABLE_BITS{1'b1}});

    // Reject bits of a first sighting: host mask plus fog, dlight and a
    // negative size in either count.
    always_comb begin
        new_rmask = r_mask;
        new_rmask[fct_pkg::REASON_FOG]      = r_mask[fct_pkg::REASON_FOG] | r_fog;
        new_rmask[fct_pkg::REASON_DLIGHT]   = r_mask[fct_pkg::REASON_DLIGHT] | r_dl;
        new_rmask[fct_pkg::REASON_GEOMETRY] = r_mask[fct_pkg::REASON_GEOMETRY]
                                              | r_points[15] | r_indices[15];
    end

    assign new_bytes = fct_pkg::cache_bytes(r_points, r_indices);

    fct_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (hash_start),
        .i_key   (i_item.face_key),
        .o_done  (hash_done),
        .o_hash  (hash_val)
    );

    fct_ram #(
        .ADDR_BITS (TABLE_BITS),
        .DATA_BITS (ENTRY_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fct_pkg::S_SWEEP: begin
                if (r_sweep == {TABLE_BITS{1'b1}}) n_state = fct_pkg::S_IDLE;
            end
            fct_pkg::S_IDLE: begin
                if (accept) begin
                    if (hash_start) n_state = fct_pkg::S_HASH;
                    else            n_state = fct_pkg::S_DONE;
                end
            end
            fct_pkg::S_HASH: begin
                if (hash_done) n_state = fct_pkg::S_PROBE;
            end
            fct_pkg::S_PROBE: begin
                if (slot_empty || slot_hit || probe_last) n_state = fct_pkg::S_DONE;
            end
            fct_pkg::S_DONE: begin
                if (out_free) begin
                    if (r_wipe) n_state = fct_pkg::S_SWEEP;
                    else        n_state = fct_pkg::S_IDLE;
                end
            end
            default: n_state = fct_pkg::S_SWEEP;
        endcase
    end

    // Outputs of the sequencer: memory controls and datapath updates.
    always_comb begin
        i_item.ready = (r_state == fct_pkg::S_IDLE);
        hash_start   = accept && (i_item.kind == fct_pkg::KIND_FACE) && r_enable
                       && (i_item.face_key != 32'd0);
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_addr  = r_idx;
        ram_wdata = '0;

        n_sweep     = r_sweep;
        n_wipe      = r_wipe;
        n_out_valid = r_out_valid && !o_result.ready;
        n_unique    = r_unique;
        n_qual      = r_qual;
        n_btot      = r_btot;
        n_sight     = r_sight;
        n_qsight    = r_qsight;
        n_oflow     = r_oflow;
        n_key       = r_key;
        n_mask      = r_mask;
        n_fog       = r_fog;
        n_dl        = r_dl;
        n_points    = r_points;
        n_indices   = r_indices;
        n_idx       = r_idx;
        n_probe     = r_probe;
        n_res       = r_res;
        n_out       = r_out;

        unique case (r_state)
            fct_pkg::S_SWEEP: begin
                ram_we   = 1'b1;
                ram_addr = r_sweep;
                n_sweep  = r_sweep + 1'b1;
            end
            fct_pkg::S_IDLE: begin
                if (accept) begin
                    n_key       = i_item.face_key;
                    n_mask      = i_item.shader_reject_mask;
                    n_fog       = i_item.fog_present;
                    n_dl        = i_item.dlight_present;
                    n_points    = i_item.point_count;
                    n_indices   = i_item.index_count;
                    n_wipe      = 1'b0;
                    n_res.slot   = '0;
                    n_res.reason = fct_pkg::REASON_NONE;
                    n_res.rmask  = '0;
                    n_res.bytes  = '0;
                    if (i_item.kind == fct_pkg::KIND_CLEAR) begin
                        // Counters clear now; the table is wiped after the result.
                        n_wipe       = 1'b1;
                        n_unique     = '0;
                        n_qual       = '0;
                        n_btot       = '0;
                        n_sight      = '0;
                        n_qsight     = '0;
                        n_oflow      = '0;
                        n_res.status = fct_pkg::STAT_CLEARED;
                    end else if (!r_enable) begin
                        n_res.status = fct_pkg::STAT_DISABLED;
                    end else if (i_item.face_key == 32'd0) begin
                        n_res.status = fct_pkg::STAT_BAD_KEY;
                    end else begin
                        n_sight = r_sight + 32'd1;
                    end
                end
            end
            fct_pkg::S_HASH: begin
                if (hash_done) begin
                    ram_re   = 1'b1;
                    ram_addr = hash_val[TABLE_BITS-1:0];
                    n_idx    = hash_val[TABLE_BITS-1:0];
                    n_probe  = '0;
                end
            end
            fct_pkg::S_PROBE: begin
                if (slot_empty) begin
                    // First sighting: claim the empty slot.
                    ram_we         = 1'b1;
                    ram_wdata.key  = r_key;
                    n_unique       = r_unique + 13'd1;
                    n_res.slot     = 12'(r_idx);
                    n_res.rmask    = new_rmask;
                    if (new_rmask != 13'd0) begin
                        n_res.reason = fct_pkg::first_reason(new_rmask);
                        n_res.status = fct_pkg::STAT_NEW_REJECT;
                    end else begin
                        ram_wdata.qual  = 1'b1;
                        ram_wdata.bytes = new_bytes;
                        n_res.bytes     = new_bytes;
                        n_qual          = r_qual + 13'd1;
                        n_btot          = r_btot + {12'd0, new_bytes};
                        n_qsight        = r_qsight + 32'd1;
                        n_res.status    = fct_pkg::STAT_NEW_QUAL;
                    end
                end else if (slot_hit) begin
                    n_res.slot = 12'(r_idx);
                    if (slot_ent.qual && (r_fog || r_dl)) begin
                        // A qualifying face seen again with fog or dlight drops out.
                        ram_we          = 1'b1;
                        ram_wdata.key   = slot_ent.key;
                        ram_wdata.qual  = 1'b0;
                        ram_wdata.bytes = slot_ent.bytes;
                        n_qual          = r_qual - 13'd1;
                        n_btot          = r_btot - {12'd0, slot_ent.bytes};
                        n_res.reason    = r_dl ? fct_pkg::REASON_DLIGHT
                                               : fct_pkg::REASON_FOG;
                        n_res.status    = fct_pkg::STAT_INVALIDATED;
                    end else if (slot_ent.qual) begin
                        n_qsight     = r_qsight + 32'd1;
                        n_res.status = fct_pkg::STAT_REPEAT_QUAL;
                    end else begin
                        n_res.status = fct_pkg::STAT_REPEAT_NOT;
                    end
                end else if (probe_last) begin
                    // Every slot was visited without a hit or a free slot.
                    n_oflow      = r_oflow + 32'd1;
                    n_res.status = fct_pkg::STAT_FULL;
                end else begin
                    ram_re   = 1'b1;
                    ram_addr = r_idx + 1'b1;
                    n_idx    = r_idx + 1'b1;
                    n_probe  = r_probe + 1'b1;
                end
            end
            fct_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_valid                 = 1'b1;
                    n_out.core                  = r_res;
                    n_out.unique_count          = r_unique;
                    n_out.qualifying_count      = r_qual;
                    n_out.total_cache_bytes     = r_btot;
                    n_out.draw_calls            = r_sight;
                    n_out.qualifying_draw_calls = r_qsight;
                    n_out.overflow_draw_calls   = r_oflow;
                    n_sweep                     = '0;
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fct_pkg::S_SWEEP;
            r_sweep     <= '0;
            r_enable    <= 1'b0;
            r_wipe      <= 1'b0;
            r_out_valid <= 1'b0;
            r_unique    <= '0;
            r_qual      <= '0;
            r_btot      <= '0;
            r_sight     <= '0;
            r_qsight    <= '0;
            r_oflow     <= '0;
        end else begin
            r_state     <= n_state;
            r_sweep     <= n_sweep;
            r_wipe      <= n_wipe;
            r_out_valid <= n_out_valid;
            r_unique    <= n_unique;
            r_qual      <= n_qual;
            r_btot      <= n_btot;
            r_sight     <= n_sight;
            r_qsight    <= n_qsight;
            r_oflow     <= n_oflow;
            if (i_cfg_we) begin
                r_enable <= i_cfg_wdata;
            end
        end
    end

    // Payload of the transaction in flight and of the waiting result.
    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_mask    <= n_mask;
        r_fog     <= n_fog;
        r_dl      <= n_dl;
        r_points  <= n_points;
        r_indices <= n_indices;
        r_idx     <= n_idx;
        r_probe   <= n_probe;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    assign o_result.valid                 = r_out_valid;
    assign o_result.status                = r_out.core.status;
    assign o_result.slot_index            = r_out.core.slot;
    assign o_result.first_reason          = r_out.core.reason;
    assign o_result.reject_mask           = r_out.core.rmask;
    assign o_result.cache_bytes           = r_out.core.bytes;
    assign o_result.unique_count          = r_out.unique_count;
    assign o_result.qualifying_count      = r_out.qualifying_count;
    assign o_result.total_cache_bytes     = r_out.total_cache_bytes;
    assign o_result.draw_calls            = r_out.draw_calls;
    assign o_result.qualifying_draw_calls = r_out.qualifying_draw_calls;
    assign o_result.overflow_draw_calls   = r_out.overflow_draw_calls;

endmodule

`default_nettype wire

/* rtl/fct_checker.sv */
// Port-level assertion checker for the face classifier hash table, with its bind.
`default_nettype none

`include "face_classifier_hash_table_core_assert.svh"

module fct_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [3:0]  i_status,
    input wire logic [11:0] i_slot,
    input wire logic [3:0]  i_reason,
    input wire logic [12:0] i_rmask,
    input wire logic [19:0] i_bytes,
    input wire logic [12:0] i_unique,
    input wire logic [12:0] i_qual,
    input wire logic [31:0] i_total,
    input wire logic [31:0] i_draws,
    input wire logic [31:0] i_qdraws,
    input wire logic [31:0] i_odraws
);

    // The block works on one transaction at a time.
    `FCT_ASSERT_NEXT(a_one_at_a_time, i_in_valid && i_in_ready, !i_in_ready, "accepted while busy")

    // A waiting result holds until taken.
    `FCT_ASSERT_NEXT(a_result_holds, i_out_valid && !i_out_ready, i_out_valid && $stable(i_status) && $stable(i_slot) && $stable(i_bytes) && $stable(i_draws), "result changed while stalled")

    // A clear result reports every counter at zero.
    `FCT_ASSERT_NOW(a_clear_zero, i_out_valid && (i_status == fct_pkg::STAT_CLEARED), (i_unique == 13'd0) && (i_qual == 13'd0) && (i_total == 32'd0) && (i_draws == 32'd0) && (i_qdraws == 32'd0) && (i_odraws == 32'd0), "counters not cleared")

    // Results that touch no slot carry no slot, mask or bytes.
    `FCT_ASSERT_NOW(a_no_slot, i_out_valid && ((i_status == fct_pkg::STAT_FULL) || (i_status == fct_pkg::STAT_DISABLED) || (i_status == fct_pkg::STAT_BAD_KEY)), (i_slot == 12'd0) && (i_rmask == 13'd0) && (i_bytes == 20'd0) && (i_reason == fct_pkg::REASON_NONE), "stray payload on slotless result")

    // A new qualifying face has no reject, a new rejected one has some.
    `FCT_ASSERT_NOW(a_new_reason, i_out_valid && ((i_status == fct_pkg::STAT_NEW_QUAL) || (i_status == fct_pkg::STAT_NEW_REJECT)), ((i_status == fct_pkg::STAT_NEW_QUAL) == (i_rmask == 13'd0)) && ((i_status == fct_pkg::STAT_NEW_QUAL) == (i_reason == fct_pkg::REASON_NONE)), "reject mask disagrees with status")

endmodule

bind face_classifier_hash_table_core fct_checker u_fct_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_status    (o_result.status),
    .i_slot      (o_result.slot_index),
    .i_reason    (o_result.first_reason),
    .i_rmask     (o_result.reject_mask),
    .i_bytes     (o_result.cache_bytes),
    .i_unique    (o_result.unique_count),
    .i_qual      (o_result.qualifying_count),
    .i_total     (o_result.total_cache_bytes),
    .i_draws     (o_result.draw_calls),
    .i_qdraws    (o_result.qualifying_draw_calls),
    .i_odraws    (o_result.overflow_draw_calls)
);

`default_nettype wire

/* verif/tb_face_classifier_hash_table_core.sv */
// Self-checking testbench for the face classifier hash table core.
`timescale 1ns / 1ps

// The testbench feeds face sightings and clear commands through the item
// channel and checks every result transaction against a predictor that keeps
// its own copy of the slot table and the running counters. The stimulus
// starts with a directed part that walks through the status codes, every
// reject reason and probing that wraps from the last slot to slot 0. After
// that come random phases built around small pools of keys, so that repeat
// sightings, invalidations and probe chains are common. Both channels idle
// at random, and the sender pauses until every expected result is back in
// the middle of each random phase.
module tb_face_classifier_hash_table_core;

    localparam int TABLE_BITS = 12;
    localparam int SLOTS = 1 << TABLE_BITS;
    // After the last result, wait for longer than one full probe so that a
    // result nobody expects still has time to show up.
    localparam int DRAIN_CYCLES = SLOTS + 128;
    // Most of a correct run is spent in the wipe pass after each clear and in
    // the longest idle gaps.
    localparam int unsigned CYCLE_LIMIT = 3_000_000;

    typedef struct packed {
        bit        kind;
        bit [31:0] key;
        bit [12:0] mask;
        bit        fog;
        bit        dlight;
        bit [15:0] points;
        bit [15:0] indices;
    } t_face_item;

    typedef struct packed {
        bit [3:0]  status;
        bit [11:0] slot;
        bit [3:0]  reason;
        bit [12:0] rmask;
        bit [19:0] bytes;
        bit [12:0] uniq;
        bit [12:0] quals;
        bit [31:0] total_bytes;
        bit [31:0] draws;
        bit [31:0] qual_draws;
        bit [31:0] overflow_draws;
    } t_face_verdict;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_wdata = 1'b0;

    fct_item_if   item_ch ();
    fct_result_if result_ch ();

    face_classifier_hash_table_core #(
        .TABLE_BITS (TABLE_BITS)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_item      (item_ch),
        .o_result    (result_ch)
    );

    // Shadow copy of the table and counters. Everything starts at zero, just
    // like the block after reset.
    bit [31:0] shadow_key [SLOTS];
    bit        shadow_qual [SLOTS];
    bit [19:0] shadow_bytes [SLOTS];
    bit [12:0] unique_faces;
    bit [12:0] live_quals;
    bit [31:0] live_bytes;
    bit [31:0] sightings;
    bit [31:0] qual_sightings;
    bit [31:0] overflow_sightings;
    bit        enable_shadow;

    t_face_item    pending_q [$];
    t_face_verdict expected_q [$];
    t_face_item    in_flight;
    t_face_verdict oldest;

    int send_gap;
    int send_calm;
    int stall_left;
    int stall_calm;
    int mismatches;
    int results_seen;
    int unsigned cycles;

    always #6 clk = ~clk;

    // Two-multiply finalizer. The low TABLE_BITS bits give the home slot.
    function automatic bit [TABLE_BITS-1:0] home_slot(bit [31:0] k);
        bit [31:0] v;
        v = k ^ (k >> 16);
        v = v * fct_pkg::HASH_MUL_A;
        v = v ^ (v >> 15);
        v = v * fct_pkg::HASH_MUL_B;
        v = v ^ (v >> 16);
        return v[TABLE_BITS-1:0];
    endfunction

    // Works out the result of one accepted transaction and updates the
    // shadow state the same way the block is supposed to.
    function automatic t_face_verdict classify_face(t_face_item it);
        t_face_verdict v;
        bit [TABLE_BITS-1:0] idx;
        bit hit;
        bit vacant;
        bit [12:0] bits;
        bit [31:0] need;
        v = '0;
        v.reason = fct_pkg::REASON_NONE;
        if (it.kind == fct_pkg::KIND_CLEAR) begin
            // A clear wipes everything, even while sightings are disabled.
            for (int s = 0; s < SLOTS; s++) begin
                shadow_key[s] = '0;
                shadow_qual[s] = 1'b0;
                shadow_bytes[s] = '0;
            end
            unique_faces = '0;
            live_quals = '0;
            live_bytes = '0;
            sightings = '0;
            qual_sightings = '0;
            overflow_sightings = '0;
            v.status = fct_pkg::STAT_CLEARED;
        end else if (!enable_shadow) begin
            v.status = fct_pkg::STAT_DISABLED;
        end else if (it.key == '0) begin
            // Key zero marks an empty slot, so it is refused and not counted.
            v.status = fct_pkg::STAT_BAD_KEY;
        end else begin
            sightings++;
            idx = home_slot(it.key);
            hit = 1'b0;
            vacant = 1'b0;
            for (int p = 0; p < SLOTS; p++) begin
                if (shadow_key[idx] == '0) begin
                    vacant = 1'b1;
                    break;
                end
                if (shadow_key[idx] == it.key) begin
                    hit = 1'b1;
                    break;
                end
                idx++;
            end
            if (!hit && !vacant) begin
                // Every slot was probed without a match or a free slot.
                overflow_sightings++;
                v.status = fct_pkg::STAT_FULL;
            end else if (hit) begin
                v.slot = 12'(idx);
                if (shadow_qual[idx] && (it.fog || it.dlight)) begin
                    // Fog or a dynamic light on a repeat sighting takes the
                    // face out of the cache; dlight is reported first.
                    shadow_qual[idx] = 1'b0;
                    live_quals--;
                    live_bytes -= 32'(shadow_bytes[idx]);
                    v.reason = it.dlight ? fct_pkg::REASON_DLIGHT : fct_pkg::REASON_FOG;
                    v.status = fct_pkg::STAT_INVALIDATED;
                end else if (shadow_qual[idx]) begin
                    qual_sightings++;
                    v.status = fct_pkg::STAT_REPEAT_QUAL;
                end else begin
                    v.status = fct_pkg::STAT_REPEAT_NOT;
                end
            end else begin
                v.slot = 12'(idx);
                shadow_key[idx] = it.key;
                unique_faces++;
                bits = it.mask;
                if (it.fog) bits[fct_pkg::REASON_FOG] = 1'b1;
                if (it.dlight) bits[fct_pkg::REASON_DLIGHT] = 1'b1;
                if (it.points[15] || it.indices[15]) bits[fct_pkg::REASON_GEOMETRY] = 1'b1;
                if (bits != '0) begin
                    for (int i = 0; i < 13; i++) begin
                        if (bits[i] && v.reason == fct_pkg::REASON_NONE) v.reason = 4'(i);
                    end
                    v.rmask = bits;
                    shadow_qual[idx] = 1'b0;
                    shadow_bytes[idx] = '0;
                    v.status = fct_pkg::STAT_NEW_REJECT;
                end else begin
                    // 24 bytes per point and 2 per index, each part rounded
                    // up to a multiple of 16.
                    need = ((32'(it.points) * 32'd24 + 32'd15) & ~32'd15)
                         + ((32'(it.indices) * 32'd2 + 32'd15) & ~32'd15);
                    v.bytes = need[19:0];
                    shadow_qual[idx] = 1'b1;
                    shadow_bytes[idx] = need[19:0];
                    live_quals++;
                    live_bytes += need;
                    qual_sightings++;
                    v.status = fct_pkg::STAT_NEW_QUAL;
                end
            end
        end
        v.uniq = unique_faces;
        v.quals = live_quals;
        v.total_bytes = live_bytes;
        v.draws = sightings;
        v.qual_draws = qual_sightings;
        v.overflow_draws = overflow_sightings;
        return v;
    endfunction

    function automatic bit [31:0] nonzero_key();
        bit [31:0] k;
        k = $urandom;
        return (k == '0) ? 32'd1 : k;
    endfunction

    // Next nonzero key at or above start whose home slot is target.
    function automatic bit [31:0] find_key_for_slot(bit [TABLE_BITS-1:0] target,
                                                    bit [31:0] start);
        bit [31:0] k;
        k = start;
        while (k == '0 || home_slot(k) != target) k++;
        return k;
    endfunction

    function automatic t_face_item make_face(bit [31:0] k, bit [12:0] m, bit fg, bit dl,
                                             bit [15:0] p, bit [15:0] ix);
        t_face_item it;
        it.kind = fct_pkg::KIND_FACE;
        it.key = k;
        it.mask = m;
        it.fog = fg;
        it.dlight = dl;
        it.points = p;
        it.indices = ix;
        return it;
    endfunction

    // Mostly small sizes, some fully random ones and now and then an extreme.
    function automatic bit [15:0] random_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return 16'($urandom_range(0, 3000));
        if (r < 92) return 16'($urandom);
        case ($urandom_range(0, 3))
            0: return 16'h0000;
            1: return 16'h7fff;
            2: return 16'h8000;
            default: return 16'hffff;
        endcase
    endfunction

    function automatic t_face_item random_face(bit [31:0] k);
        bit [12:0] m;
        if ($urandom_range(0, 9) < 6) m = '0;
        else if ($urandom_range(0, 1) == 1) m = 13'(1 << $urandom_range(0, 12));
        else m = 13'($urandom);
        return make_face(k, m, $urandom_range(0, 99) < 12, $urandom_range(0, 99) < 12,
                         random_count(), random_count());
    endfunction

    function automatic t_face_item clear_item();
        t_face_item it;
        it = random_face(nonzero_key());
        it.kind = fct_pkg::KIND_CLEAR;
        return it;
    endfunction

    // Idle length for either side: mostly short, a few long, and now and
    // then a stretch of transactions with no idling at all.
    task automatic pick_idle(inout int calm, output int len);
        int r;
        r = $urandom_range(0, 99);
        if (calm > 0) begin
            calm--;
            len = 0;
        end else if (r < 3) begin
            calm = $urandom_range(20, 80);
            len = 0;
        end else if (r < 45) begin
            len = 0;
        end else if (r < 85) begin
            len = $urandom_range(1, 3);
        end else if (r < 97) begin
            len = $urandom_range(4, 12);
        end else begin
            len = $urandom_range(20, 60);
        end
    endtask

    // Returns at a falling edge once every queued item has been sent and
    // every expected result has come back.
    task automatic wait_for_drain();
        @(negedge clk);
        while (pending_q.size() != 0 || item_ch.valid || expected_q.size() != 0)
            @(negedge clk);
    endtask

    // The enable register is only written while nothing is in flight.
    task automatic write_enable(bit on);
        wait_for_drain();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= on;
        enable_shadow = on;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // A random phase. Most sightings reuse a small pool of keys, and some
    // pool keys share a home slot with the key before them, so that probe
    // chains form. The sender stops halfway until everything has drained.
    task automatic queue_mixed_phase(int count, int pool_size);
        bit [31:0] pool [$];
        t_face_item it;
        int r;
        for (int i = 0; i < pool_size; i++) begin
            if (i % 6 == 5) pool.push_back(find_key_for_slot(home_slot(pool[i-1]), pool[i-1] + 1));
            else pool.push_back(nonzero_key());
        end
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) wait_for_drain();
            r = $urandom_range(0, 99);
            if (r < 2) it = clear_item();
            else if (r < 5) it = random_face('0);
            else if (r < 13) it = random_face(nonzero_key());
            else it = random_face(pool[$urandom_range(0, pool_size - 1)]);
            pending_q.push_back(it);
        end
    endtask

    task automatic check_field(string name, bit [31:0] want, logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d: %s expected 0x%0h, got 0x%0h",
                         results_seen, name, want, got);
        end
    endtask

    // Sender. A new item goes out once the previous transaction has been
    // accepted and the random gap after it has run out. The prediction is
    // made at the edge that accepts the transaction.
    always @(posedge clk) begin
        if (!rst_n) begin
            item_ch.valid <= 1'b0;
        end else begin
            if (item_ch.valid && item_ch.ready) begin
                expected_q.push_back(classify_face(in_flight));
                pick_idle(send_calm, send_gap);
            end
            if (!item_ch.valid || item_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    item_ch.valid <= 1'b0;
                end else if (pending_q.size() != 0) begin
                    in_flight = pending_q.pop_front();
                    item_ch.valid <= 1'b1;
                    item_ch.kind <= in_flight.kind;
                    item_ch.face_key <= in_flight.key;
                    item_ch.shader_reject_mask <= in_flight.mask;
                    item_ch.fog_present <= in_flight.fog;
                    item_ch.dlight_present <= in_flight.dlight;
                    item_ch.point_count <= in_flight.points;
                    item_ch.index_count <= in_flight.indices;
                end else begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver. Every accepted result is compared with the oldest
    // prediction; ready drops for random stretches.
    always @(posedge clk) begin
        if (!rst_n) begin
            result_ch.ready <= 1'b0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                results_seen++;
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d arrived with nothing expected", results_seen);
                end else begin
                    oldest = expected_q.pop_front();
                    check_field("status", oldest.status, result_ch.status);
                    check_field("slot_index", oldest.slot, result_ch.slot_index);
                    check_field("first_reason", oldest.reason, result_ch.first_reason);
                    check_field("reject_mask", oldest.rmask, result_ch.reject_mask);
                    check_field("cache_bytes", oldest.bytes, result_ch.cache_bytes);
                    check_field("unique_count", oldest.uniq, result_ch.unique_count);
                    check_field("qualifying_count", oldest.quals, result_ch.qualifying_count);
                    check_field("total_cache_bytes", oldest.total_bytes,
                                result_ch.total_cache_bytes);
                    check_field("draw_calls", oldest.draws, result_ch.draw_calls);
                    check_field("qualifying_draw_calls", oldest.qual_draws,
                                result_ch.qualifying_draw_calls);
                    check_field("overflow_draw_calls", oldest.overflow_draws,
                                result_ch.overflow_draw_calls);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= 1'b1;
                if ($urandom_range(0, 99) < 25) pick_idle(stall_calm, stall_left);
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        bit [31:0] ka;
        bit [31:0] kb;
        bit [31:0] kw1;
        bit [31:0] kw2;

        item_ch.valid = 1'b0;
        item_ch.kind = fct_pkg::KIND_FACE;
        item_ch.face_key = '0;
        item_ch.shader_reject_mask = '0;
        item_ch.fog_present = 1'b0;
        item_ch.dlight_present = 1'b0;
        item_ch.point_count = '0;
        item_ch.index_count = '0;
        result_ch.ready = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // With classification off, sightings are ignored but a clear still
        // wipes the table.
        write_enable(1'b0);
        pending_q.push_back(random_face(nonzero_key()));
        pending_q.push_back(clear_item());
        pending_q.push_back(random_face('0));
        write_enable(1'b1);

        // Directed part: the status codes, every reject source and the probe
        // wrapping from the last slot back to slot 0.
        ka = nonzero_key();
        kb = nonzero_key();
        kw1 = find_key_for_slot(TABLE_BITS'(SLOTS - 1), nonzero_key());
        kw2 = find_key_for_slot(TABLE_BITS'(SLOTS - 1), kw1 + 1);
        pending_q.push_back(make_face('0, 13'h1fff, 1'b1, 1'b1, 16'h8000, 16'h8000));
        // Largest possible cache footprint.
        pending_q.push_back(make_face(ka, '0, 1'b0, 1'b0, 16'h7fff, 16'h7fff));
        pending_q.push_back(make_face(ka, '0, 1'b0, 1'b0, 16'd3, 16'd5));
        pending_q.push_back(make_face(ka, '0, 1'b1, 1'b0, 16'd0, 16'd0));
        pending_q.push_back(make_face(ka, '0, 1'b0, 1'b0, 16'd0, 16'd0));
        pending_q.push_back(make_face(kb, '0, 1'b0, 1'b0, 16'd0, 16'd0));
        // Fog and dlight together: dlight is the reason given.
        pending_q.push_back(make_face(kb, '0, 1'b1, 1'b1, 16'd1, 16'd1));
        pending_q.push_back(make_face(nonzero_key(), 13'h1fff, 1'b0, 1'b0, 16'd1, 16'd1));
        pending_q.push_back(make_face(nonzero_key(), 13'h0c00, 1'b0, 1'b0, 16'd4, 16'd6));
        pending_q.push_back(make_face(nonzero_key(), '0, 1'b1, 1'b0, 16'd4, 16'd6));
        pending_q.push_back(make_face(nonzero_key(), '0, 1'b0, 1'b1, 16'd4, 16'd6));
        pending_q.push_back(make_face(nonzero_key(), '0, 1'b0, 1'b0, 16'h8000, 16'd0));
        pending_q.push_back(make_face(nonzero_key(), '0, 1'b0, 1'b0, 16'd0, 16'hffff));
        pending_q.push_back(make_face(32'hffff_ffff, '0, 1'b0, 1'b0, 16'd1, 16'd1));
        pending_q.push_back(make_face(32'h0000_0001, 13'h1000, 1'b0, 1'b0, 16'd7, 16'd9));
        // Both keys start at the last slot, so the second lands in slot 0.
        pending_q.push_back(make_face(kw1, '0, 1'b0, 1'b0, 16'd2, 16'd2));
        pending_q.push_back(make_face(kw2, '0, 1'b0, 1'b0, 16'd8, 16'd30));
        pending_q.push_back(make_face(kw2, '0, 1'b0, 1'b0, 16'd0, 16'd0));
        pending_q.push_back(make_face(kw1, '0, 1'b0, 1'b1, 16'd0, 16'd0));
        pending_q.push_back(clear_item());
        pending_q.push_back(make_face(ka, '0, 1'b0, 1'b0, 16'd10, 16'd12));

        write_enable(1'b1);
        queue_mixed_phase(400, 24);
        write_enable(1'b0);
        queue_mixed_phase(60, 8);
        write_enable(1'b1);
        queue_mixed_phase(450, 64);
        write_enable(1'b1);
        queue_mixed_phase(450, 200);
        write_enable(1'b0);
        pending_q.push_back(random_face(nonzero_key()));
        write_enable(1'b1);
        pending_q.push_back(random_face(ka));
        pending_q.push_back(random_face(nonzero_key()));

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
